/* src/dre_pkg.sv */
package dre_pkg;

    // Defaults for the top-level parameters
    localparam int LANES_DEF     = 5;
    localparam int TIME_BITS_DEF = 40;

    // Register reset value: smallest nonzero time step, in 2^-16 s
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd7;

    // Quotient bits produced by the serial divider
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Operation codes on the func field
    typedef enum logic [1:0] {
        FN_RESET   = 2'd0,
        FN_ADD_EST = 2'd1,
        FN_ADD_VEL = 2'd2,
        FN_READ    = 2'd3
    } fn_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RST,
        ST_RST_AIM,
        ST_ADD_CHK,
        ST_EV_CHK,
        ST_BLEND,
        ST_MR,
        ST_CLAMP,
        ST_AIM_TIME,
        ST_AIM_MAG,
        ST_GAP,
        ST_MUL,
        ST_MUL_ACC,
        ST_DIV_INIT,
        ST_DIV_ITER,
        ST_DIV_FIN,
        ST_DONE
    } st_t;

    // What a multiply pass reads and writes
    typedef enum logic [1:0] {
        MS_RESET,
        MS_READ,
        MS_SNAP,
        MS_AIM
    } ms_t;

    // What a divide pass reads and writes
    typedef enum logic {
        DS_EST,
        DS_SNAP
    } ds_t;

endpackage

/* src/dead_reckoning_extrapolator.sv */
// Read and reset run one multiply pass over the lanes; a stale add runs no pass at all.
// An add runs two multiply passes and up to one divide pass, up to two when it estimates velocity.
// One transaction is in flight at a time; in_stall stays high until the result is taken.
// The rate is set by the shared divider (one quotient bit per cycle)
// and the shared 32x32 multiplier.
// Reset (rst_n low, asynchronous) clears all track state to zero and min_interval to 7.
module dead_reckoning_extrapolator #(
    parameter int LANES     = dre_pkg::LANES_DEF,
    parameter int TIME_BITS = dre_pkg::TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [39:0]         sent_time,
    input  logic [39:0]         now_time,
    input  logic signed [31:0]  pos_0,
    input  logic signed [31:0]  pos_1,
    input  logic signed [31:0]  pos_2,
    input  logic signed [31:0]  pos_3,
    input  logic signed [31:0]  pos_4,
    input  logic signed [31:0]  vel_0,
    input  logic signed [31:0]  vel_1,
    input  logic signed [31:0]  vel_2,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_pos_0,
    output logic signed [31:0]  out_pos_1,
    output logic signed [31:0]  out_pos_2,
    output logic signed [31:0]  out_pos_3,
    output logic signed [31:0]  out_pos_4,
    output logic                in_range,
    output logic                accepted,
    output logic [39:0]         latency_est,
    output logic [39:0]         update_est
);

    localparam int TB = TIME_BITS;
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);
    localparam logic [dre_pkg::CNT_W-1:0] LAST_STEP = dre_pkg::CNT_W'(dre_pkg::DIV_STEPS - 1);

    // Saturating time add
    function automatic logic [TIME_BITS-1:0] tadd(input logic [TIME_BITS-1:0] a,
                                                  input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    // Estimate update: up by half the step, down by ceil(step/8)
    function automatic logic [TIME_BITS-1:0] blend(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        if (b > a)
            return (a >> 1) + (b >> 1) + TIME_BITS'(a[0] & b[0]);
        return a - (d >> 3) - TIME_BITS'(d[2:0] != 3'd0);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
        if (x > 42'sh0007fffffff)
            return 32'sh7fffffff;
        if (x < -42'sh00080000000)
            return -32'sh80000000;
        return x[31:0];
    endfunction

    // Lane staging of the input fields
    logic signed [31:0] pos_w  [5];
    logic signed [31:0] vel_w  [3];
    logic signed [31:0] lane_pos [LANES];
    logic signed [31:0] lane_vel [LANES];
    logic signed [31:0] out_w  [5];

    assign pos_w[0] = pos_0;
    assign pos_w[1] = pos_1;
    assign pos_w[2] = pos_2;
    assign pos_w[3] = pos_3;
    assign pos_w[4] = pos_4;
    assign vel_w[0] = vel_0;
    assign vel_w[1] = vel_1;
    assign vel_w[2] = vel_2;

    // Registers
    dre_pkg::st_t          state_reg, state_next;
    dre_pkg::fn_t          func_reg, func_next;
    dre_pkg::ms_t          mul_sel_reg, mul_sel_next;
    dre_pkg::ds_t          div_sel_reg, div_sel_next;
    logic [LW-1:0]         lane_reg, lane_next;
    logic [dre_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]           min_int_reg, min_int_next;
    logic                  in_range_reg, in_range_next;
    logic                  accepted_reg, accepted_next;

    logic [TB-1:0]         lst_reg, lst_next;
    logic [TB-1:0]         snap_time_reg, snap_time_next;
    logic [TB-1:0]         aim_time_reg, aim_time_next;
    logic [TB-1:0]         upd_reg, upd_next;
    logic [TB-1:0]         lat_avg_reg, lat_avg_next;
    logic signed [31:0]    last_pos_reg [LANES];
    logic signed [31:0]    last_pos_next [LANES];
    logic signed [31:0]    snap_pos_reg [LANES];
    logic signed [31:0]    snap_pos_next [LANES];
    logic signed [31:0]    snap_vel_reg [LANES];
    logic signed [31:0]    snap_vel_next [LANES];
    logic signed [31:0]    aim_pos_reg [LANES];
    logic signed [31:0]    aim_pos_next [LANES];

    // Transaction payload and scratch
    logic [TB-1:0]         pt_reg, pt_next;
    logic [TB-1:0]         nt_reg, nt_next;
    logic signed [31:0]    in_pos_reg [LANES];
    logic signed [31:0]    in_pos_next [LANES];
    logic signed [31:0]    in_vel_reg [LANES];
    logic signed [31:0]    in_vel_next [LANES];
    logic signed [31:0]    rd_reg [LANES];
    logic signed [31:0]    rd_next [LANES];
    logic [TB-1:0]         tmp_reg, tmp_next;
    logic [TB-1:0]         den_reg, den_next;
    logic [TB-1:0]         mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic                  gneg_reg, gneg_next;
    logic [63:0]           prod_reg, prod_next;
    logic                  mul_neg_reg, mul_neg_next;
    logic                  mul_cap_reg, mul_cap_next;
    logic [TB-1:0]         rem_reg, rem_next;
    logic [31:0]           dq_reg, dq_next;
    logic                  dneg_reg, dneg_next;
    logic                  ovf_reg, ovf_next;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane_in
            if (g < 5) begin : g_pos
                assign lane_pos[g] = pos_w[g];
            end else begin : g_pos_zero
                assign lane_pos[g] = '0;
            end
            if (g < 3) begin : g_vel
                assign lane_vel[g] = vel_w[g];
            end else begin : g_vel_zero
                assign lane_vel[g] = '0;
            end
        end
        for (g = 0; g < 5; g++) begin : g_lane_out
            if (g < LANES) begin : g_out
                assign out_w[g] = rd_reg[g];
            end else begin : g_out_zero
                assign out_w[g] = '0;
            end
        end
    endgenerate

    // Port outputs
    assign in_stall    = (state_reg != dre_pkg::ST_IDLE);
    assign out_valid   = (state_reg == dre_pkg::ST_DONE);
    assign out_pos_0   = out_w[0];
    assign out_pos_1   = out_w[1];
    assign out_pos_2   = out_w[2];
    assign out_pos_3   = out_w[3];
    assign out_pos_4   = out_w[4];
    assign in_range    = in_range_reg;
    assign accepted    = accepted_reg;
    assign latency_est = 40'(lat_avg_reg);
    assign update_est  = 40'(upd_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dre_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (dre_pkg::fn_t'(func))
                        dre_pkg::FN_RESET:   state_next = dre_pkg::ST_RST;
                        dre_pkg::FN_READ:    state_next = dre_pkg::ST_MR;
                        dre_pkg::FN_ADD_EST,
                        dre_pkg::FN_ADD_VEL: state_next = dre_pkg::ST_ADD_CHK;
                        default:             state_next = dre_pkg::ST_ADD_CHK;
                    endcase
                end
            end
            dre_pkg::ST_RST:      state_next = dre_pkg::ST_RST_AIM;
            dre_pkg::ST_RST_AIM:  state_next = dre_pkg::ST_MUL;
            dre_pkg::ST_ADD_CHK:
            begin
                if (pt_reg <= lst_reg)
                    state_next = dre_pkg::ST_DONE;
                else
                    state_next = dre_pkg::ST_EV_CHK;
            end
            dre_pkg::ST_EV_CHK:
            begin
                if (func_reg == dre_pkg::FN_ADD_EST && den_reg > TB'(min_int_reg))
                    state_next = dre_pkg::ST_DIV_INIT;
                else
                    state_next = dre_pkg::ST_BLEND;
            end
            dre_pkg::ST_BLEND:    state_next = dre_pkg::ST_MR;
            dre_pkg::ST_MR:       state_next = dre_pkg::ST_CLAMP;
            dre_pkg::ST_CLAMP:    state_next = dre_pkg::ST_MUL;
            dre_pkg::ST_AIM_TIME: state_next = dre_pkg::ST_AIM_MAG;
            dre_pkg::ST_AIM_MAG:  state_next = dre_pkg::ST_MUL;
            dre_pkg::ST_GAP:
            begin
                if (den_reg < TB'(min_int_reg) || den_reg == '0)
                    state_next = dre_pkg::ST_DONE;
                else
                    state_next = dre_pkg::ST_DIV_INIT;
            end
            dre_pkg::ST_MUL:      state_next = dre_pkg::ST_MUL_ACC;
            dre_pkg::ST_MUL_ACC:
            begin
                if (lane_reg != LAST_LANE)
                    state_next = dre_pkg::ST_MUL;
                else
                begin
                    unique case (mul_sel_reg)
                        dre_pkg::MS_RESET: state_next = dre_pkg::ST_DONE;
                        dre_pkg::MS_READ:  state_next = dre_pkg::ST_DONE;
                        dre_pkg::MS_SNAP:  state_next = dre_pkg::ST_AIM_TIME;
                        dre_pkg::MS_AIM:   state_next = dre_pkg::ST_GAP;
                        default:           state_next = dre_pkg::ST_DONE;
                    endcase
                end
            end
            dre_pkg::ST_DIV_INIT: state_next = dre_pkg::ST_DIV_ITER;
            dre_pkg::ST_DIV_ITER:
            begin
                if (cnt_reg == LAST_STEP)
                    state_next = dre_pkg::ST_DIV_FIN;
            end
            dre_pkg::ST_DIV_FIN:
            begin
                if (lane_reg != LAST_LANE)
                    state_next = dre_pkg::ST_DIV_INIT;
                else if (div_sel_reg == dre_pkg::DS_EST)
                    state_next = dre_pkg::ST_BLEND;
                else
                    state_next = dre_pkg::ST_DONE;
            end
            dre_pkg::ST_DONE:
            begin
                if (!out_stall)
                    state_next = dre_pkg::ST_IDLE;
            end
            default:              state_next = dre_pkg::ST_IDLE;
        endcase
    end

    // Datapath and sequencer outputs
    always_comb
    begin
        logic [TB-1:0]         t_c;
        logic                  ok;
        logic signed [31:0]    v_sel;
        logic [31:0]           vm;
        logic [47:0]           psh;
        logic [40:0]           p;
        logic signed [41:0]    term;
        logic signed [41:0]    base;
        logic signed [31:0]    res;
        logic signed [32:0]    diff;
        logic [32:0]           dmag;
        logic [TB:0]           shifted;
        logic                  gneg_eff;
        logic                  fneg;
        logic [31:0]           lim;
        logic [31:0]           qc;

        t_c      = nt_reg;
        ok       = 1'b1;
        v_sel    = '0;
        vm       = '0;
        psh      = '0;
        p        = '0;
        term     = '0;
        base     = '0;
        res      = '0;
        diff     = '0;
        dmag     = '0;
        shifted  = '0;
        gneg_eff = 1'b0;
        fneg     = 1'b0;
        lim      = '0;
        qc       = '0;

        func_next     = func_reg;
        mul_sel_next  = mul_sel_reg;
        div_sel_next  = div_sel_reg;
        lane_next     = lane_reg;
        cnt_next      = cnt_reg;
        min_int_next  = cfg_we ? cfg_wdata : min_int_reg;
        in_range_next = in_range_reg;
        accepted_next = accepted_reg;
        lst_next       = lst_reg;
        snap_time_next = snap_time_reg;
        aim_time_next  = aim_time_reg;
        upd_next       = upd_reg;
        lat_avg_next   = lat_avg_reg;
        last_pos_next  = last_pos_reg;
        snap_pos_next  = snap_pos_reg;
        snap_vel_next  = snap_vel_reg;
        aim_pos_next   = aim_pos_reg;
        pt_next        = pt_reg;
        nt_next        = nt_reg;
        in_pos_next    = in_pos_reg;
        in_vel_next    = in_vel_reg;
        rd_next        = rd_reg;
        tmp_next       = tmp_reg;
        den_next       = den_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        gneg_next      = gneg_reg;
        prod_next      = prod_reg;
        mul_neg_next   = mul_neg_reg;
        mul_cap_next   = mul_cap_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        dneg_next      = dneg_reg;
        ovf_next       = ovf_reg;

        unique case (state_reg)
            // Take the transaction
            dre_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next     = dre_pkg::fn_t'(func);
                    pt_next       = TB'(sent_time);
                    nt_next       = TB'(now_time);
                    in_pos_next   = lane_pos;
                    in_vel_next   = lane_vel;
                    in_range_next = 1'b0;
                    accepted_next = (dre_pkg::fn_t'(func) != dre_pkg::FN_READ);
                    for (int i = 0; i < LANES; i++)
                        rd_next[i] = '0;
                end
            end

            // Reset the track to the sample
            dre_pkg::ST_RST:
            begin
                mag_next       = (nt_reg > pt_reg) ? nt_reg - pt_reg : '0;
                neg_next       = 1'b0;
                lst_next       = pt_reg;
                snap_time_next = nt_reg;
                last_pos_next  = in_pos_reg;
                snap_pos_next  = in_pos_reg;
                snap_vel_next  = in_vel_reg;
            end
            dre_pkg::ST_RST_AIM:
            begin
                upd_next      = mag_reg;
                lat_avg_next  = mag_reg;
                aim_time_next = tadd(nt_reg, mag_reg);
                mul_sel_next  = dre_pkg::MS_RESET;
                lane_next     = '0;
            end

            // Staleness check, sample gap and latency sample
            dre_pkg::ST_ADD_CHK:
            begin
                den_next = pt_reg - lst_reg;
                tmp_next = (nt_reg > pt_reg) ? nt_reg - pt_reg : '0;
                if (pt_reg <= lst_reg)
                    accepted_next = 1'b0;
            end
            dre_pkg::ST_EV_CHK:
            begin
                lane_next    = '0;
                div_sel_next = dre_pkg::DS_EST;
                gneg_next    = 1'b0;
                if (func_reg == dre_pkg::FN_ADD_EST && !(den_reg > TB'(min_int_reg)))
                begin
                    for (int i = 0; i < LANES; i++)
                        in_vel_next[i] = '0;
                end
            end
            dre_pkg::ST_BLEND:
            begin
                lat_avg_next  = blend(lat_avg_reg, tmp_reg);
                upd_next      = blend(upd_reg, den_reg);
                last_pos_next = in_pos_reg;
                lst_next      = pt_reg;
            end

            // Read window end, then clamp the time
            dre_pkg::ST_MR:
            begin
                tmp_next = tadd(aim_time_reg, upd_reg);
            end
            dre_pkg::ST_CLAMP:
            begin
                if (t_c < snap_time_reg)
                begin
                    t_c = snap_time_reg;
                    ok  = 1'b0;
                end
                if (t_c > tmp_reg)
                begin
                    t_c = tmp_reg;
                    ok  = 1'b0;
                end
                if (t_c >= snap_time_reg)
                begin
                    mag_next = t_c - snap_time_reg;
                    neg_next = 1'b0;
                end
                else
                begin
                    mag_next = snap_time_reg - t_c;
                    neg_next = 1'b1;
                end
                in_range_next = ok && (func_reg == dre_pkg::FN_READ);
                mul_sel_next  = (func_reg == dre_pkg::FN_READ) ? dre_pkg::MS_READ
                                                                : dre_pkg::MS_SNAP;
                lane_next     = '0;
            end

            // Plan the aim point
            dre_pkg::ST_AIM_TIME:
            begin
                aim_time_next  = tadd(nt_reg, upd_reg);
                snap_time_next = nt_reg;
            end
            dre_pkg::ST_AIM_MAG:
            begin
                mag_next     = (aim_time_reg >= pt_reg) ? aim_time_reg - pt_reg
                                                        : pt_reg - aim_time_reg;
                neg_next     = (aim_time_reg < pt_reg);
                den_next     = (aim_time_reg >= nt_reg) ? aim_time_reg - nt_reg
                                                        : nt_reg - aim_time_reg;
                gneg_next    = (aim_time_reg < nt_reg);
                mul_sel_next = dre_pkg::MS_AIM;
                lane_next    = '0;
            end
            dre_pkg::ST_GAP:
            begin
                lane_next    = '0;
                div_sel_next = dre_pkg::DS_SNAP;
                if (den_reg < TB'(min_int_reg) || den_reg == '0)
                    snap_vel_next = in_vel_reg;
            end

            // Shared multiplier: velocity magnitude times low time word
            dre_pkg::ST_MUL:
            begin
                if (mul_sel_reg == dre_pkg::MS_READ || mul_sel_reg == dre_pkg::MS_SNAP)
                    v_sel = snap_vel_reg[lane_reg];
                else
                    v_sel = in_vel_reg[lane_reg];
                vm           = v_sel[31] ? 32'(-v_sel) : 32'(v_sel);
                prod_next    = 64'(vm) * 64'(32'(mag_reg));
                mul_neg_next = v_sel[31] ^ neg_reg;
                mul_cap_next = (vm != '0) && ((mag_reg >> 32) != '0);
            end
            dre_pkg::ST_MUL_ACC:
            begin
                psh = prod_reg[63:16];
                if (mul_cap_reg || psh > 48'h0100_0000_0000)
                    p = 41'h100_0000_0000;
                else
                    p = psh[40:0];
                term = mul_neg_reg ? -$signed({1'b0, p}) : $signed({1'b0, p});
                if (mul_sel_reg == dre_pkg::MS_READ || mul_sel_reg == dre_pkg::MS_SNAP)
                    base = 42'(snap_pos_reg[lane_reg]);
                else
                    base = 42'(in_pos_reg[lane_reg]);
                res = sat32(base + term);
                unique case (mul_sel_reg)
                    dre_pkg::MS_RESET: aim_pos_next[lane_reg]  = res;
                    dre_pkg::MS_AIM:   aim_pos_next[lane_reg]  = res;
                    dre_pkg::MS_READ:  rd_next[lane_reg]       = res;
                    dre_pkg::MS_SNAP:  snap_pos_next[lane_reg] = res;
                    default:           rd_next[lane_reg]       = res;
                endcase
                if (lane_reg != LAST_LANE)
                    lane_next = lane_reg + 1'b1;
            end

            // Shared divider: load the position difference
            dre_pkg::ST_DIV_INIT:
            begin
                if (div_sel_reg == dre_pkg::DS_EST)
                    diff = 33'(in_pos_reg[lane_reg]) - 33'(last_pos_reg[lane_reg]);
                else
                    diff = 33'(aim_pos_reg[lane_reg]) - 33'(snap_pos_reg[lane_reg]);
                dneg_next = diff[32];
                dmag      = diff[32] ? 33'(-diff) : 33'(diff);
                rem_next  = TB'(dmag[32:16]);
                dq_next   = {dmag[15:0], 16'h0000};
                ovf_next  = (TB'(dmag[32:16]) >= den_reg);
                cnt_next  = '0;
            end
            dre_pkg::ST_DIV_ITER:
            begin
                shifted = {rem_reg, dq_reg[31]};
                if (shifted >= {1'b0, den_reg})
                begin
                    rem_next = TB'(shifted - {1'b0, den_reg});
                    dq_next  = {dq_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[TB-1:0];
                    dq_next  = {dq_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            dre_pkg::ST_DIV_FIN:
            begin
                gneg_eff = (div_sel_reg == dre_pkg::DS_SNAP) && gneg_reg;
                fneg     = dneg_reg ^ gneg_eff;
                lim      = (fneg && !gneg_eff) ? 32'h8000_0000 : 32'h7fff_ffff;
                qc       = (ovf_reg || dq_reg > lim) ? lim : dq_reg;
                res      = fneg ? $signed(-qc) : $signed(qc);
                if (div_sel_reg == dre_pkg::DS_EST)
                    in_vel_next[lane_reg] = res;
                else
                    snap_vel_next[lane_reg] = res;
                if (lane_reg != LAST_LANE)
                    lane_next = lane_reg + 1'b1;
            end

            dre_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control and track state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dre_pkg::ST_IDLE;
            func_reg      <= dre_pkg::FN_RESET;
            mul_sel_reg   <= dre_pkg::MS_RESET;
            div_sel_reg   <= dre_pkg::DS_EST;
            lane_reg      <= '0;
            cnt_reg       <= '0;
            min_int_reg   <= dre_pkg::MIN_INTERVAL_RST;
            in_range_reg  <= 1'b0;
            accepted_reg  <= 1'b0;
            lst_reg       <= '0;
            snap_time_reg <= '0;
            aim_time_reg  <= '0;
            upd_reg       <= '0;
            lat_avg_reg   <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                last_pos_reg[i] <= '0;
                snap_pos_reg[i] <= '0;
                snap_vel_reg[i] <= '0;
                aim_pos_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            mul_sel_reg   <= mul_sel_next;
            div_sel_reg   <= div_sel_next;
            lane_reg      <= lane_next;
            cnt_reg       <= cnt_next;
            min_int_reg   <= min_int_next;
            in_range_reg  <= in_range_next;
            accepted_reg  <= accepted_next;
            lst_reg       <= lst_next;
            snap_time_reg <= snap_time_next;
            aim_time_reg  <= aim_time_next;
            upd_reg       <= upd_next;
            lat_avg_reg   <= lat_avg_next;
            last_pos_reg  <= last_pos_next;
            snap_pos_reg  <= snap_pos_next;
            snap_vel_reg  <= snap_vel_next;
            aim_pos_reg   <= aim_pos_next;
        end
    end

    // Payload and scratch
    always_ff @(posedge clk)
    begin
        pt_reg      <= pt_next;
        nt_reg      <= nt_next;
        in_pos_reg  <= in_pos_next;
        in_vel_reg  <= in_vel_next;
        rd_reg      <= rd_next;
        tmp_reg     <= tmp_next;
        den_reg     <= den_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        gneg_reg    <= gneg_next;
        prod_reg    <= prod_next;
        mul_neg_reg <= mul_neg_next;
        mul_cap_reg <= mul_cap_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        dneg_reg    <= dneg_next;
        ovf_reg     <= ovf_next;
    end

endmodule

/* src/dre_checker.sv */
module dre_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic signed [31:0]  out_pos_0,
    input logic                in_range,
    input logic                accepted,
    input logic [39:0]         latency_est
);

    // One transaction in flight: no new input while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // An accepted transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after accept");

    // Accepted adds and resets give no positions and no range flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (!in_range && out_pos_0 == 32'sd0))
        else $error("non-read transaction returned read data");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(out_pos_0) && $stable(latency_est)))
        else $error("stalled result changed");

endmodule

bind dead_reckoning_extrapolator dre_checker u_dre_checker (.*);
